>>> design/led64_pkg.sv
// Shared types, constants and round functions of the LED-style 64-bit block cipher.
package led64_pkg;

    localparam int unsigned LED_ROUNDS = 8;
    localparam logic [63:0] KEY_RESET  = 64'h0123_4567_89AB_CDEF;

    typedef logic [0:15][3:0] cells_t;

    typedef enum logic {
        KIND_ENCRYPT = 1'b0,
        KIND_DECRYPT = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] state;
    } lane_t;

    localparam cells_t FWD_BOX = 64'hC56B_90AD_3EF8_4712;
    localparam cells_t INV_BOX = 64'h5EF8_C12D_B463_079A;
    localparam cells_t MIX_FWD = 64'h4122_8656_BEA9_22FB;
    localparam cells_t MIX_INV = 64'hCCD4_3845_762E_D99D;

    function automatic logic [5:0] round_const(input logic [2:0] t);
        logic [5:0] rc;
        case (t)
            3'd0:    rc = 6'h01;
            3'd1:    rc = 6'h03;
            3'd2:    rc = 6'h07;
            3'd3:    rc = 6'h0F;
            3'd4:    rc = 6'h1F;
            3'd5:    rc = 6'h3E;
            3'd6:    rc = 6'h3D;
            3'd7:    rc = 6'h3B;
            default: rc = 6'h01;
        endcase
        return rc;
    endfunction

    function automatic logic [3:0] gf16_mul(input logic [3:0] x, input logic [3:0] y);
        logic [4:0] a;
        logic [3:0] p;
        a = {1'b0, x};
        p = 4'h0;
        for (int n = 0; n < 4; n++) begin
            if (y[n]) begin
                p = p ^ a[3:0];
            end
            a = {a[3:0], 1'b0};
            if (a[4]) begin
                a = a ^ 5'h13;
            end
        end
        return p;
    endfunction

    function automatic cells_t add_const(input cells_t c, input logic [5:0] rc);
        cells_t t;
        t = c;
        t[0]  = t[0]  ^ 4'h4;
        t[4]  = t[4]  ^ 4'h5;
        t[8]  = t[8]  ^ 4'h2;
        t[12] = t[12] ^ 4'h3;
        t[1]  = t[1]  ^ {1'b0, rc[5:3]};
        t[5]  = t[5]  ^ {1'b0, rc[2:0]};
        t[9]  = t[9]  ^ {1'b0, rc[5:3]};
        t[13] = t[13] ^ {1'b0, rc[2:0]};
        return t;
    endfunction

    function automatic cells_t sub_cells(input cells_t c, input cells_t box);
        cells_t t;
        for (int n = 0; n < 16; n++) begin
            t[n] = box[c[n]];
        end
        return t;
    endfunction

    function automatic cells_t shift_left(input cells_t c);
        cells_t t;
        for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
                t[4*r + j] = c[4*r + ((j + r) & 3)];
            end
        end
        return t;
    endfunction

    function automatic cells_t shift_right(input cells_t c);
        cells_t t;
        for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
                t[4*r + j] = c[4*r + ((j + 4 - r) & 3)];
            end
        end
        return t;
    endfunction

    function automatic cells_t mix_cols(input cells_t c, input cells_t m);
        cells_t     t;
        logic [3:0] acc;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                acc = 4'h0;
                for (int k = 0; k < 4; k++) begin
                    acc = acc ^ gf16_mul(m[4*i + k], c[4*k + j]);
                end
                t[4*i + j] = acc;
            end
        end
        return t;
    endfunction

    function automatic logic [63:0] enc_round(input logic [63:0] s, input logic [63:0] k,
                                              input logic [5:0] rc);
        cells_t c;
        c = cells_t'(s ^ k);
        c = add_const(c, rc);
        c = sub_cells(c, FWD_BOX);
        c = shift_left(c);
        c = mix_cols(c, MIX_FWD);
        return 64'(c);
    endfunction

    function automatic logic [63:0] dec_round(input logic [63:0] s, input logic [63:0] k,
                                              input logic [5:0] rc);
        cells_t c;
        c = cells_t'(s ^ k);
        c = mix_cols(c, MIX_INV);
        c = shift_right(c);
        c = sub_cells(c, INV_BOX);
        c = add_const(c, rc);
        return 64'(c);
    endfunction

endpackage

>>> design/led64_round_cell.sv
// One round cell of the cipher pipeline: a registered encrypt or decrypt round.
module led64_round_cell #(
    parameter int unsigned STAGE  = 0,
    parameter int unsigned ROUNDS = led64_pkg::LED_ROUNDS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [63:0]       key,
    input  logic              in_valid,
    output logic              in_ready,
    input  led64_pkg::lane_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output led64_pkg::lane_t  out_data
);
    import led64_pkg::*;

    localparam logic [2:0] ENC_IDX = 3'(STAGE);
    localparam logic [2:0] DEC_IDX = 3'(ROUNDS - 1 - STAGE);

    logic  valid_reg;
    logic  valid_next;
    lane_t data_reg;
    lane_t data_next;
    logic  take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_comb begin
        data_next      = data_reg;
        if (take) begin
            data_next.kind = in_data.kind;
            if (in_data.kind == KIND_DECRYPT) begin
                data_next.state = dec_round(in_data.state, key, round_const(DEC_IDX));
            end else begin
                data_next.state = enc_round(in_data.state, key, round_const(ENC_IDX));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> design/led64_block_cipher_core.sv
// Top level of the LED-style 64-bit block cipher: key register and chain of round cells.
//
//  channel   direction  handshake          payload
//  s_        in         s_tvalid/s_tready  s_tdata = block_in, s_tuser = kind
//  m_        out        m_tvalid/m_tready  m_tdata = block_out
//  cfg_      in         cfg_wr_en          cfg_wr_data = cipher_key
//
// One block per cycle sustained while the output is not stalled; each round cell registers the block once.
// Each cell holds one block and passes it on when the next cell can take it.
// A stalled output blocks only the cells that are full; empty cells still accept.
// Reset clears every cell's valid flag and loads the key reset value.
module led64_block_cipher_core #(
    parameter int unsigned ROUNDS = led64_pkg::LED_ROUNDS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // [63:0] block_in
    input  logic        s_tuser,     // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,     // [63:0] block_out
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data
);
    import led64_pkg::*;

    logic [63:0] key_reg;
    logic [63:0] key_next;

    logic  chain_valid [ROUNDS+1];
    logic  chain_ready [ROUNDS+1];
    lane_t chain_data  [ROUNDS+1];

    assign key_next = cfg_wr_en ? cfg_wr_data : key_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= KEY_RESET;
        end else begin
            key_reg <= key_next;
        end
    end

    assign chain_valid[0]      = s_tvalid;
    assign s_tready            = chain_ready[0];
    assign chain_data[0].kind  = kind_t'(s_tuser);
    assign chain_data[0].state = s_tdata;

    for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
        led64_round_cell #(
            .STAGE  (g),
            .ROUNDS (ROUNDS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .key       (key_reg),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    assign m_tvalid            = chain_valid[ROUNDS];
    assign chain_ready[ROUNDS] = m_tready;
    assign m_tdata             = chain_data[ROUNDS].state ^ key_reg;

endmodule

>>> design/led64_checker.sv
// Port-level checks of the block cipher core and their attachment to it.
module led64_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result presented right after reset");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while the output side drains");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result data changed while stalled");

endmodule

bind led64_block_cipher_core led64_checker u_led64_checker (.*);
